[sv/assert_macros.svh]
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/allm_pkg.sv]
`timescale 1ns / 1ps
package allm_pkg;
	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W_DEF   = 32;
	localparam int OP_W         = 3;
	localparam int VALUE_W      = 32;
	localparam int IDX_W        = 6;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 7;
	localparam int IN_W         = OP_W + VALUE_W + IDX_W;
	localparam int OUT_W        = STATUS_W + IDX_W + VALUE_W + COUNT_W;

	localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OP_W-1:0] OP_REMVAL = 3'd1;
	localparam logic [OP_W-1:0] OP_POP    = 3'd2;
	localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
	localparam logic [OP_W-1:0] OP_REMSLT = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic load;       // capture input item
		logic scan_init;  // cursor <= search start
		logic scan_step;  // cursor <= cursor + 1 (wrap)
		logic walk_init;  // cursor <= head
		logic walk_step;  // cursor <= next of current
		logic slot_init;  // cursor <= slot index
		logic rd;         // issue memory read at cursor
		logic do_add;     // link cursor at head
		logic ul_a;       // unlink phase a: fix neighbors
		logic ul_b;       // unlink phase b: clear slot
		logic rd_val;     // capture payload as out value
	} allm_cmd_t;

	typedef struct packed {
		logic free_hit;     // slot at cursor is free
		logic scan_last;    // scanned all slots
		logic empty;        // head is none
		logic cur_none;     // cursor is none
		logic val_hit;      // payload read matches
		logic walk_last;    // step limit reached
		logic slot_ok;      // slot index occupied
		logic full;         // total equals capacity
	} allm_sts_t;
endpackage

[sv/allm_stream_if.sv]
`timescale 1ns / 1ps
interface allm_stream_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[sv/allm_datapath.sv]
`timescale 1ns / 1ps
module allm_datapath import allm_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int DATA_W   = DATA_W_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  allm_cmd_t           cmd,
	input  logic [VALUE_W-1:0]  in_value,
	input  logic [IDX_W-1:0]    in_slot,
	output allm_sts_t           sts,
	output logic [IDX_W-1:0]    res_slot,
	output logic [VALUE_W-1:0]  res_value,
	output logic [COUNT_W-1:0]  res_count
);
	localparam int AW = $clog2(CAPACITY);
	localparam int LW = AW + 1;
	localparam logic [LW-1:0] NONE = LW'(CAPACITY);

	logic [CAPACITY-1:0] occ_q;
	logic [LW-1:0]       next_mem [CAPACITY];
	logic [LW-1:0]       prev_mem [CAPACITY];
	logic [DATA_W-1:0]   pay_mem  [CAPACITY];
	logic [LW-1:0]       head_q, tail_q, cur_q, steps_q;
	logic [AW-1:0]       start_q;
	logic [LW-1:0]       total_q;
	logic [DATA_W-1:0]   val_q, pay_rd_q;
	logic [LW-1:0]       nxt_rd_q, prv_rd_q;
	logic [IDX_W-1:0]    slot_q;
	logic [VALUE_W-1:0]  oval_q;
	logic [AW-1:0]       ca;

	assign ca = cur_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			head_q  <= NONE;
			tail_q  <= NONE;
			start_q <= '0;
			total_q <= '0;
			cur_q   <= '0;
			steps_q <= '0;
		end else begin
			if (cmd.scan_init) begin
				cur_q   <= {1'b0, start_q};
				steps_q <= '0;
			end
			if (cmd.scan_step) begin
				cur_q   <= (ca == AW'(CAPACITY - 1)) ? '0 : cur_q + 1'b1;
				steps_q <= steps_q + 1'b1;
			end
			if (cmd.walk_init) begin
				cur_q   <= head_q;
				steps_q <= '0;
			end
			if (cmd.walk_step) begin
				cur_q   <= nxt_rd_q;
				steps_q <= steps_q + 1'b1;
			end
			if (cmd.slot_init)
				cur_q <= LW'(in_slot);
			if (cmd.do_add) begin
				occ_q[ca] <= 1'b1;
				head_q  <= cur_q;
				if (tail_q == NONE)
					tail_q <= cur_q;
				start_q <= ca;
				total_q <= total_q + 1'b1;
			end
			if (cmd.ul_a) begin
				if (cur_q == head_q)
					head_q <= nxt_rd_q;
				if (cur_q == tail_q)
					tail_q <= prv_rd_q;
			end
			if (cmd.ul_b) begin
				occ_q[ca] <= 1'b0;
				if (total_q != '0)
					total_q <= total_q - 1'b1;
				start_q <= ca;
			end
		end
	end

	// link and payload memories; payload has one write port, link memories are written at several addresses
	always_ff @(posedge clk) begin
		if (cmd.load)
			val_q <= DATA_W'(in_value);
		if (cmd.rd) begin
			pay_rd_q <= pay_mem[ca];
			nxt_rd_q <= next_mem[ca];
			prv_rd_q <= prev_mem[ca];
		end
		if (cmd.do_add) begin
			pay_mem[ca]  <= val_q;
			next_mem[ca] <= head_q;
			prev_mem[ca] <= NONE;
		end
		if (cmd.ul_a && prv_rd_q != NONE)
			next_mem[prv_rd_q[AW-1:0]] <= nxt_rd_q;
		if (cmd.ul_a && nxt_rd_q != NONE)
			prev_mem[nxt_rd_q[AW-1:0]] <= prv_rd_q;
		if (cmd.ul_b) begin
			next_mem[ca] <= NONE;
			prev_mem[ca] <= NONE;
		end
		// old head gets new prev on add (separate cycle via ul path not needed)
		if (cmd.do_add && head_q != NONE)
			prev_mem[head_q[AW-1:0]] <= cur_q;
		if (cmd.load) begin
			slot_q <= '0;
			oval_q <= '0;
		end
		if (cmd.do_add || cmd.ul_b)
			slot_q <= IDX_W'(ca);
		if (cmd.rd_val) begin
			slot_q <= IDX_W'(ca);
			oval_q <= VALUE_W'(pay_rd_q);
		end
	end

	assign sts.free_hit  = !occ_q[ca];
	assign sts.scan_last = steps_q == LW'(CAPACITY - 1);
	assign sts.empty     = head_q == NONE;
	assign sts.cur_none  = cur_q == NONE;
	assign sts.val_hit   = pay_rd_q == val_q;
	assign sts.walk_last = steps_q == LW'(CAPACITY);
	assign sts.slot_ok   = (int'(in_slot) < CAPACITY) && occ_q[AW'(in_slot)];
	assign sts.full      = total_q == NONE;

	assign res_slot  = slot_q;
	assign res_value = oval_q;
	assign res_count = COUNT_W'(total_q);
endmodule

[sv/allm_ctrl.sv]
`timescale 1ns / 1ps
module allm_ctrl import allm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     in_op,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] out_status,
	input  allm_sts_t           sts,
	output allm_cmd_t           cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_WRD   = 4'd3;
	localparam logic [3:0] S_WCHK  = 4'd4;
	localparam logic [3:0] S_URD   = 4'd5;
	localparam logic [3:0] S_UWT   = 4'd6;
	localparam logic [3:0] S_UA    = 4'd7;
	localparam logic [3:0] S_UB    = 4'd8;
	localparam logic [3:0] S_PKRD  = 4'd9;
	localparam logic [3:0] S_PKWT  = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0]          state_q, state_d;
	logic [OP_W-1:0]     op_q;
	logic [STATUS_W-1:0] st_q, st_d;

	assign in_ready   = state_q == S_IDLE;
	assign out_valid  = state_q == S_OUT;
	assign out_status = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_ADD;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (in_valid && in_ready)
				op_q <= in_op;
		end
	end

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				st_d    = ST_OK;
				state_d = S_OUT;
				case (op_q) inside
					OP_ADD: begin
						if (sts.full) st_d = ST_FULL;
						else begin
							cmd.scan_init = 1'b1;
							state_d = S_SCAN;
						end
					end
					OP_REMVAL, OP_POP, OP_PEEK, OP_REMSLT: begin
						if (sts.empty) st_d = ST_EMPTY;
						else if (op_q == OP_REMVAL) begin
							cmd.walk_init = 1'b1;
							state_d = S_WRD;
						end else if (op_q == OP_REMSLT) begin
							if (sts.slot_ok) begin
								cmd.slot_init = 1'b1;
								state_d = S_URD;
							end else st_d = ST_NOTFOUND;
						end else begin
							cmd.walk_init = 1'b1;
							state_d = S_PKRD;
						end
					end
					default: st_d = ST_NOTFOUND;
				endcase
			end
			S_SCAN: begin
				if (sts.free_hit) begin
					cmd.do_add = 1'b1;
					state_d = S_OUT;
				end else if (sts.scan_last) begin
					st_d = ST_FULL;
					state_d = S_OUT;
				end else cmd.scan_step = 1'b1;
			end
			S_WRD: begin
				if (sts.cur_none || sts.walk_last) begin
					st_d = ST_NOTFOUND;
					state_d = S_OUT;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_WCHK;
				end
			end
			S_WCHK: begin
				if (sts.val_hit) state_d = S_UA;
				else begin
					cmd.walk_step = 1'b1;
					state_d = S_WRD;
				end
			end
			S_URD: begin
				cmd.rd = 1'b1;
				state_d = S_UWT;
			end
			S_UWT: state_d = S_UA;
			S_UA: begin
				cmd.ul_a = 1'b1;
				state_d = S_UB;
			end
			S_UB: begin
				cmd.ul_b = 1'b1;
				state_d = S_OUT;
			end
			S_PKRD: begin
				cmd.rd = 1'b1;
				state_d = S_PKWT;
			end
			S_PKWT: begin
				cmd.rd_val = 1'b1;
				state_d = (op_q == OP_POP) ? S_UA : S_OUT;
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

[sv/array_linked_list_manager_unit.sv]
// peek reads the head entry; pop reads it and unlinks it; slot removal reads the given slot
// and unlinks it; empty list, full list, unused slot and bad op are answered at dispatch
// add does a next-fit scan for a free slot; value removal walks from the head, unlinking
// the first match, else not found; one transaction in flight, next accepted after result
// asynchronous active-low reset empties the list; link memories need no clearing pass
`timescale 1ns / 1ps
module array_linked_list_manager_unit import allm_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int DATA_W   = DATA_W_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	allm_stream_if.sink   in_ch,
	allm_stream_if.source out_ch
);
`include "assert_macros.svh"

	allm_cmd_t cmd;
	allm_sts_t sts;
	logic [IDX_W-1:0]    slot_q;
	logic [OP_W-1:0]     op;
	logic [VALUE_W-1:0]  value;
	logic [IDX_W-1:0]    slot_index;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    slot_used_index;
	logic [VALUE_W-1:0]  out_value;
	logic [COUNT_W-1:0]  element_count;

	assign {op, value, slot_index} = in_ch.data;
	assign out_ch.data = {status, slot_used_index, out_value, element_count};

	always_ff @(posedge clk)
		if (in_ch.valid && in_ch.ready)
			slot_q <= slot_index;

	allm_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_op (op),
		.out_valid (out_ch.valid), .out_ready (out_ch.ready), .out_status (status),
		.sts, .cmd
	);

	allm_datapath #(.CAPACITY(CAPACITY), .DATA_W(DATA_W)) u_dp (
		.clk, .arst_n, .cmd,
		.in_value (value), .in_slot (cmd.load ? slot_index : slot_q),
		.sts, .res_slot (slot_used_index), .res_value (out_value), .res_count (element_count)
	);

	`ASSERT_IMPL(a_no_overlap, clk, arst_n, out_ch.valid, !in_ch.ready, "busy while result held")
	`ASSERT_IMPL(a_one_mod, clk, arst_n, cmd.do_add, !cmd.ul_a && !cmd.ul_b, "add and unlink")
	`ASSERT_NEXT(a_ua_ub, clk, arst_n, cmd.ul_a, cmd.ul_b, "unlink phases split")
endmodule
